// ===== hw/rtl/samn_pkg.sv =====
// Package for the sensor array min/max normalizer.
// Holds the op codes, the half-dark codes and the sequencer state type.
// No dependencies.
package samn_pkg;

   // Width of the op selector carried in tuser.
   localparam int OP_BITS = 2;

   // Operations carried with each input item.
   localparam logic [OP_BITS-1:0] OP_SEED      = 2'd0;
   localparam logic [OP_BITS-1:0] OP_CALIBRATE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_MEASURE   = 2'd2;

   // Number of channels in each half that the half-dark flag looks at.
   localparam int HALF_SPAN = 4;

   // Codes of the half-dark result field.
   localparam int HALF_BITS = 2;
   localparam logic [HALF_BITS-1:0] HALF_NONE  = 2'd0;
   localparam logic [HALF_BITS-1:0] HALF_LEFT  = 2'd1;
   localparam logic [HALF_BITS-1:0] HALF_RIGHT = 2'd2;

   // Flag bits that follow the levels in the result item.
   localparam int FLAG_BITS = 3 + HALF_BITS;

   // Measure sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

// ===== hw/rtl/sensor_array_minmax_normalizer.sv =====
// Top level of the sensor array min/max normalizer: calibration registers,
// a shared bit-serial divider and the result register.
// Depends on samn_pkg.
//
// Usage:
//   Each input item on the req_ channel is one frame of CHANNELS raw samples
//   plus an op in req_tuser. Seed loads every channel's minimum and maximum
//   with the samples; calibrate widens them; both finish at the accepting
//   edge and give no result item. Op value 3 is dropped.
//   Measure gives one result item on the rsp_ channel: CHANNELS levels in
//   unsigned Q1.FRACTION_BITS, then all_dark, all_light, any_dark, half_dark.
//   Levels come from one restoring divider that makes one quotient bit a
//   cycle and serves the channels in turn: each channel has a setup step,
//   then the divide steps, one per quotient bit, or the setup step only when
//   its level is 0 or full. Once the last channel is done, the result goes
//   to the output register as soon as that register is free.
//   req_tready is high whenever the divider is idle, also while a result
//   still waits in the output register; a stalled receiver holds the next
//   measure in its finish step only. csr_wr_en writes dark_threshold, and the
//   user must see that it is used only while the block is idle; the block does not enforce this.
//   Reset sets each minimum to all ones, each maximum to zero, the
//   threshold to one half, and empties the output register.
module sensor_array_minmax_normalizer
   import samn_pkg::*;
#(
   parameter int CHANNELS      = 7,
   parameter int SAMPLE_BITS   = 10,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // Configuration: dark_threshold
   input  logic                                       csr_wr_en,
   input  logic [FRACTION_BITS:0]                     csr_wr_data,
   // Input items
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // tdata: sample_0 .. sample_{CHANNELS-1}, then zero fill
   input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0]  req_tdata,
   // tuser: op
   input  logic [OP_BITS-1:0]                         req_tuser,
   // Result items
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // tdata: level_0 .. level_{CHANNELS-1}, all_dark, all_light, any_dark,
   // half_dark, then zero fill
   output logic [((CHANNELS*(FRACTION_BITS+1)+FLAG_BITS+7)/8)*8-1:0] rsp_tdata
);

   localparam int LEVEL_BITS = FRACTION_BITS + 1;
   localparam int RSP_BITS   = ((CHANNELS*LEVEL_BITS+FLAG_BITS+7)/8)*8;
   localparam int FLAG_LSB   = CHANNELS*LEVEL_BITS;
   localparam int CH_BITS    = $clog2(CHANNELS);
   localparam int CNT_BITS   = $clog2(FRACTION_BITS+1);
   localparam logic [CH_BITS-1:0]    LAST_CH   = CH_BITS'(CHANNELS-1);
   localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = LEVEL_BITS'(1) << FRACTION_BITS;
   localparam logic [LEVEL_BITS-1:0] THRESH_RESET = LEVEL_BITS'(1) << (FRACTION_BITS-1);
   localparam logic [CNT_BITS-1:0]   CNT_FULL  = CNT_BITS'(FRACTION_BITS);
   localparam logic [CNT_BITS-1:0]   CNT_LAST  = CNT_BITS'(1);

   // Registers and their next values
   state_type                state_ff, state_in;
   logic [CH_BITS-1:0]       ch_ff, ch_in;
   logic [SAMPLE_BITS-1:0]   rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0]   div_ff, div_in;
   logic [FRACTION_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [LEVEL_BITS-1:0]    thresh_ff, thresh_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]      rsp_data_ff, rsp_data_in;
   logic [SAMPLE_BITS-1:0]   min_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0]   min_in [CHANNELS];
   logic [SAMPLE_BITS-1:0]   max_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0]   max_in [CHANNELS];
   logic [SAMPLE_BITS-1:0]   sample_ff [CHANNELS];
   logic [LEVEL_BITS-1:0]    level_ff [CHANNELS];

   // Combinational helpers
   logic [SAMPLE_BITS-1:0]   req_sample [CHANNELS];
   logic                     req_accept;
   logic                     sample_load;
   logic                     lvl_we;
   logic [LEVEL_BITS-1:0]    lvl_wdata;
   logic                     chan_done;
   logic [SAMPLE_BITS-1:0]   cur_s, cur_lo, cur_hi;
   logic [SAMPLE_BITS:0]     rem_dbl, rem_diff;
   logic                     rem_ge;
   logic                     all_dark, all_light, any_dark, left_dark, right_dark;
   logic [HALF_BITS-1:0]     half_dark;

   // Unpack the input samples.
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         req_sample[i] = req_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
   end

   assign req_accept = req_tvalid && req_tready;

   // Currently served channel and one step of restoring division.
   assign cur_s    = sample_ff[ch_ff];
   assign cur_lo   = min_ff[ch_ff];
   assign cur_hi   = max_ff[ch_ff];
   assign rem_dbl  = {rem_ff, 1'b0};
   assign rem_diff = rem_dbl - {1'b0, div_ff};
   assign rem_ge   = (rem_dbl >= {1'b0, div_ff});

   // Threshold flags over all finished levels.
   always_comb begin
      all_dark   = 1'b1;
      all_light  = 1'b1;
      any_dark   = 1'b0;
      left_dark  = 1'b1;
      right_dark = 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
         if (level_ff[i] < thresh_ff) begin
            all_dark = 1'b0;
         end
         if (level_ff[i] > thresh_ff) begin
            all_light = 1'b0;
            any_dark  = 1'b1;
         end
         if (i < HALF_SPAN && !(level_ff[i] > thresh_ff)) begin
            left_dark = 1'b0;
         end
         if (i >= CHANNELS - HALF_SPAN && !(level_ff[i] > thresh_ff)) begin
            right_dark = 1'b0;
         end
      end
      if (left_dark) begin
         half_dark = HALF_LEFT;
      end else if (right_dark) begin
         half_dark = HALF_RIGHT;
      end else begin
         half_dark = HALF_NONE;
      end
   end

   // Next state and outputs of the sequencer.
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      thresh_in    = csr_wr_en ? csr_wr_data : thresh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      sample_load  = 1'b0;
      lvl_we       = 1'b0;
      lvl_wdata    = '0;
      chan_done    = 1'b0;
      req_tready   = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         min_in[i] = min_ff[i];
         max_in[i] = max_ff[i];
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               unique case (req_tuser)
                  OP_SEED: begin
                     for (int i = 0; i < CHANNELS; i++) begin
                        min_in[i] = req_sample[i];
                        max_in[i] = req_sample[i];
                     end
                  end
                  OP_CALIBRATE: begin
                     for (int i = 0; i < CHANNELS; i++) begin
                        if (req_sample[i] > max_ff[i]) begin
                           max_in[i] = req_sample[i];
                        end
                        if (req_sample[i] < min_ff[i]) begin
                           min_in[i] = req_sample[i];
                        end
                     end
                  end
                  OP_MEASURE: begin
                     sample_load = 1'b1;
                     ch_in       = '0;
                     state_in    = ST_SETUP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SETUP: begin
            // Empty range or sample at or below the minimum reads as 0, at or
            // past the maximum as full; only the rest goes through the divider.
            if (cur_hi <= cur_lo || cur_s <= cur_lo) begin
               lvl_we    = 1'b1;
               lvl_wdata = '0;
               chan_done = 1'b1;
            end else if (cur_s >= cur_hi) begin
               lvl_we    = 1'b1;
               lvl_wdata = LEVEL_ONE;
               chan_done = 1'b1;
            end else begin
               rem_in   = cur_s - cur_lo;
               div_in   = cur_hi - cur_lo;
               quo_in   = '0;
               cnt_in   = CNT_FULL;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in = rem_ge ? rem_diff[SAMPLE_BITS-1:0] : rem_dbl[SAMPLE_BITS-1:0];
            quo_in = {quo_ff[FRACTION_BITS-2:0], rem_ge};
            cnt_in = cnt_ff - CNT_LAST;
            if (cnt_ff == CNT_LAST) begin
               lvl_we    = 1'b1;
               lvl_wdata = {1'b0, quo_in};
               chan_done = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in = '0;
               for (int i = 0; i < CHANNELS; i++) begin
                  rsp_data_in[i*LEVEL_BITS +: LEVEL_BITS] = level_ff[i];
               end
               rsp_data_in[FLAG_LSB]                   = all_dark;
               rsp_data_in[FLAG_LSB+1]                 = all_light;
               rsp_data_in[FLAG_LSB+2]                 = any_dark;
               rsp_data_in[FLAG_LSB+3 +: HALF_BITS]    = half_dark;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Move on to the next channel, or to the result once all are done.
      if (chan_done) begin
         if (ch_ff == LAST_CH) begin
            state_in = ST_FINISH;
         end else begin
            ch_in    = ch_ff + CH_BITS'(1);
            state_in = ST_SETUP;
         end
      end
   end

   // Control state, calibration and threshold registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= THRESH_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            min_ff[i] <= '1;
            max_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         thresh_ff    <= thresh_in;
         for (int i = 0; i < CHANNELS; i++) begin
            min_ff[i] <= min_in[i];
            max_ff[i] <= max_in[i];
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      if (sample_load) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sample_ff[i] <= req_sample[i];
         end
      end
      if (lvl_we) begin
         level_ff[ch_ff] <= lvl_wdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The partial remainder stays below the divisor while dividing.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> rem_ff < div_ff)
      else $error("remainder not below divisor during division");

   // A measure item always starts the sequencer at its setup step.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser == OP_MEASURE |=> state_ff == ST_SETUP && ch_ff == '0)
      else $error("measure item did not start the sequencer");

   // A level above the threshold rules out an all-light result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[FLAG_LSB+2] |-> !rsp_data_ff[FLAG_LSB+1])
      else $error("any_dark and all_light both set");

   // The half-dark code is one of its three meanings.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[FLAG_LSB+3 +: HALF_BITS] != 2'd3)
      else $error("half_dark holds an unused code");

   // No level ever exceeds full scale.
   generate
      for (genvar g = 0; g < CHANNELS; g++) begin : g_level_chk
         assert property (@(posedge clock) disable iff (reset)
            rsp_valid_ff |-> rsp_data_ff[g*LEVEL_BITS +: LEVEL_BITS] <= LEVEL_ONE)
            else $error("level above full scale");
      end
   endgenerate

endmodule

// ===== tb/sensor_array_minmax_normalizer_test.sv =====
// Self-checking testbench for the sensor array min/max normalizer.
// It predicts each measure result from its own calibration state and compares field by field.
// Depends on samn_pkg and sensor_array_minmax_normalizer.
module sensor_array_minmax_normalizer_test;
   import samn_pkg::*;

   localparam int CHANNELS      = 7;
   localparam int SAMPLE_BITS   = 10;
   localparam int FRACTION_BITS = 8;
   localparam int LEVEL_BITS    = FRACTION_BITS + 1;
   localparam int REQ_W = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((CHANNELS * (FRACTION_BITS + 1) + FLAG_BITS + 7) / 8) * 8;
   localparam int LEVEL_ONE = 1 << FRACTION_BITS;
   localparam int SAMPLE_TOP = (1 << SAMPLE_BITS) - 1;
   localparam int SETTLE_CYCLES = 80;
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] frame_type;

   // Same bit order as rsp_tdata without the zero fill.
   typedef struct packed {
      logic [HALF_BITS-1:0]                       half_dark;
      logic                                       any_dark;
      logic                                       all_light;
      logic                                       all_dark;
      logic [CHANNELS-1:0][FRACTION_BITS:0]       level;
   } measure_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [FRACTION_BITS:0] csr_wr_data;
   logic                 req_tvalid;
   logic                 req_tready;
   // tdata: sample_0 .. sample_6, then zero fill
   logic [REQ_W-1:0]     req_tdata;
   // tuser: op
   logic [OP_BITS-1:0]   req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   // tdata: level_0 .. level_6, all_dark, all_light, any_dark, half_dark, then zero fill
   logic [RSP_W-1:0]     rsp_tdata;

   // Mirror of the block's calibration state and threshold.
   logic [SAMPLE_BITS-1:0]   chan_lo [CHANNELS];
   logic [SAMPLE_BITS-1:0]   chan_hi [CHANNELS];
   logic [FRACTION_BITS:0]   dark_level;

   measure_type pending_measures [$];
   int       mismatch_count;
   bit       steady_flow;
   int       stall_left;

   sensor_array_minmax_normalizer #(
      .CHANNELS      (CHANNELS),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short pauses, now and then a long one, none in steady phases.
   function automatic int idle_length();
      int r;
      r = $urandom_range(99);
      if (steady_flow || r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] clip_sample(int v);
      if (v < 0) begin
         return '0;
      end
      if (v > SAMPLE_TOP) begin
         return SAMPLE_TOP[SAMPLE_BITS-1:0];
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   // Truncated (s - lo) / (hi - lo) in Q1.8, saturated to one.
   function automatic logic [FRACTION_BITS:0] scale_sample(logic [SAMPLE_BITS-1:0] s,
                                                           logic [SAMPLE_BITS-1:0] lo,
                                                           logic [SAMPLE_BITS-1:0] hi);
      logic [SAMPLE_BITS+FRACTION_BITS-1:0] num;
      logic [SAMPLE_BITS+FRACTION_BITS-1:0] quot;
      if (hi <= lo || s <= lo) begin
         return '0;
      end
      num = {{FRACTION_BITS{1'b0}}, s} - {{FRACTION_BITS{1'b0}}, lo};
      num = num << FRACTION_BITS;
      quot = num / ({{FRACTION_BITS{1'b0}}, hi} - {{FRACTION_BITS{1'b0}}, lo});
      if (quot > LEVEL_ONE) begin
         quot = LEVEL_ONE[SAMPLE_BITS+FRACTION_BITS-1:0];
      end
      return quot[FRACTION_BITS:0];
   endfunction

   // Applies one accepted item to the mirrored state; a measure queues its result.
   task automatic track_frame(logic [OP_BITS-1:0] op, frame_type frame);
      measure_type m;
      bit left_dark;
      bit right_dark;
      m = '0;
      left_dark = 1'b1;
      right_dark = 1'b1;
      case (op)
         OP_SEED: begin
            for (int i = 0; i < CHANNELS; i++) begin
               chan_lo[i] = frame[i];
               chan_hi[i] = frame[i];
            end
         end
         OP_CALIBRATE: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (frame[i] > chan_hi[i]) chan_hi[i] = frame[i];
               if (frame[i] < chan_lo[i]) chan_lo[i] = frame[i];
            end
         end
         OP_MEASURE: begin
            m.all_dark = 1'b1;
            m.all_light = 1'b1;
            for (int i = 0; i < CHANNELS; i++) begin
               m.level[i] = scale_sample(frame[i], chan_lo[i], chan_hi[i]);
               if (m.level[i] < dark_level) m.all_dark = 1'b0;
               if (m.level[i] > dark_level) begin
                  m.all_light = 1'b0;
                  m.any_dark = 1'b1;
               end
               if (i < HALF_SPAN && !(m.level[i] > dark_level)) left_dark = 1'b0;
               if (i >= CHANNELS - HALF_SPAN && !(m.level[i] > dark_level)) right_dark = 1'b0;
            end
            if (left_dark) begin
               m.half_dark = HALF_LEFT;
            end else if (right_dark) begin
               m.half_dark = HALF_RIGHT;
            end else begin
               m.half_dark = HALF_NONE;
            end
            pending_measures.push_back(m);
         end
         default: begin
            // The unused op leaves everything as it was.
         end
      endcase
   endtask

   // Presents one item after a random pause and waits until it is accepted.
   task automatic send_frame(logic [OP_BITS-1:0] op, frame_type frame);
      int gap;
      gap = idle_length();
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {{(REQ_W - CHANNELS * SAMPLE_BITS){1'b0}}, frame};
      do begin
         @(posedge clock);
      end while (!req_tready);
      track_frame(op, frame);
   endtask

   // Drops valid, waits for every outstanding result and lets the divider settle.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_measures.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [FRACTION_BITS:0] value);
      wait_idle();
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      dark_level = value;
   endtask

   function automatic frame_type flat_frame(int v);
      frame_type f;
      for (int i = 0; i < CHANNELS; i++) begin
         f[i] = clip_sample(v);
      end
      return f;
   endfunction

   function automatic frame_type list_frame(int s0, int s1, int s2, int s3, int s4, int s5,
                                            int s6);
      frame_type f;
      f[0] = clip_sample(s0);
      f[1] = clip_sample(s1);
      f[2] = clip_sample(s2);
      f[3] = clip_sample(s3);
      f[4] = clip_sample(s4);
      f[5] = clip_sample(s5);
      f[6] = clip_sample(s6);
      return f;
   endfunction

   // Measure straight after reset: every range is empty, so every level is zero.
   task automatic test_reset_state();
      send_frame(OP_MEASURE, list_frame(0, SAMPLE_TOP, 512, 1, 1022, 300, 700));
   endtask

   // A seed alone gives an empty range; the unused op must not touch the state.
   task automatic test_seed_and_unused_op();
      send_frame(OP_SEED, list_frame(100, 200, 300, 400, 500, 600, 700));
      send_frame(OP_UNUSED, flat_frame(SAMPLE_TOP));
      send_frame(OP_MEASURE, list_frame(100, 201, 350, SAMPLE_TOP, 0, 600, 900));
   endtask

   // Full-scale range: both sample extremes and some points in between.
   task automatic test_full_range();
      send_frame(OP_SEED, flat_frame(512));
      send_frame(OP_CALIBRATE, flat_frame(0));
      send_frame(OP_CALIBRATE, flat_frame(SAMPLE_TOP));
      send_frame(OP_MEASURE, list_frame(0, SAMPLE_TOP, 512, 1, 1022, 256, 768));
      send_frame(OP_MEASURE, flat_frame(SAMPLE_TOP));
      send_frame(OP_MEASURE, flat_frame(0));
   endtask

   // Samples below the minimum read zero, samples above the maximum saturate.
   task automatic test_clamping();
      send_frame(OP_SEED, flat_frame(300));
      send_frame(OP_CALIBRATE, flat_frame(600));
      send_frame(OP_MEASURE, list_frame(0, 299, 300, 301, 599, 600, SAMPLE_TOP));
   endtask

   // Range 0..256 makes each level equal to its sample, so the flags can be aimed.
   task automatic test_dark_flags();
      send_frame(OP_SEED, flat_frame(0));
      send_frame(OP_CALIBRATE, flat_frame(LEVEL_ONE));
      send_frame(OP_MEASURE, flat_frame(128));
      send_frame(OP_MEASURE, list_frame(200, 200, 200, 200, 0, 0, 0));
      send_frame(OP_MEASURE, list_frame(0, 0, 0, 200, 200, 200, 200));
      send_frame(OP_MEASURE, flat_frame(200));
      send_frame(OP_MEASURE, list_frame(200, 200, 200, 0, 200, 200, 200));
      send_frame(OP_MEASURE, list_frame(129, 128, 127, 129, 129, 129, 129));
   endtask

   // Threshold extremes, including one above full scale that no level can exceed.
   task automatic test_threshold_extremes();
      write_threshold('0);
      send_frame(OP_MEASURE, flat_frame(0));
      write_threshold(LEVEL_BITS'(LEVEL_ONE));
      send_frame(OP_MEASURE, flat_frame(LEVEL_ONE));
      write_threshold('1);
      send_frame(OP_MEASURE, flat_frame(SAMPLE_TOP));
      write_threshold(LEVEL_BITS'(128));
   endtask

   function automatic frame_type random_frame();
      frame_type f;
      for (int i = 0; i < CHANNELS; i++) begin
         f[i] = SAMPLE_BITS'($urandom_range(SAMPLE_TOP));
      end
      return f;
   endfunction

   // Calibration samples that either stay close to the seed or roam freely.
   function automatic frame_type calibration_frame(frame_type seed, bit narrow);
      frame_type f;
      for (int i = 0; i < CHANNELS; i++) begin
         if (narrow) begin
            f[i] = clip_sample(int'(seed[i]) + $urandom_range(0, 80) - 40);
         end else begin
            f[i] = SAMPLE_BITS'($urandom_range(SAMPLE_TOP));
         end
      end
      return f;
   endfunction

   // Measure samples aimed around the current ranges so every level region shows up.
   function automatic frame_type measure_frame();
      frame_type f;
      int bias;
      int pick;
      bias = $urandom_range(4);
      for (int i = 0; i < CHANNELS; i++) begin
         pick = (bias == 4) ? $urandom_range(3) : bias;
         case (pick)
            0: f[i] = SAMPLE_BITS'($urandom_range(SAMPLE_TOP));
            1: f[i] = clip_sample(int'(chan_lo[i]) + $urandom_range(0, 10) - 5);
            2: f[i] = clip_sample(int'(chan_hi[i]) + $urandom_range(0, 10) - 5);
            default: begin
               if (chan_hi[i] > chan_lo[i]) begin
                  f[i] = SAMPLE_BITS'($urandom_range(chan_hi[i], chan_lo[i]));
               end else begin
                  f[i] = SAMPLE_BITS'($urandom_range(SAMPLE_TOP));
               end
            end
         endcase
      end
      return f;
   endfunction

   // Mostly seed, calibrate and measure sequences with random content, some noise.
   task automatic test_random_traffic(int item_goal, logic [FRACTION_BITS:0] threshold,
                                      bit steady);
      int sent;
      frame_type seed;
      bit narrow;
      logic [OP_BITS-1:0] op;
      write_threshold(threshold);
      steady_flow = steady;
      sent = 0;
      while (sent < item_goal) begin
         if ($urandom_range(99) < 80) begin
            seed = random_frame();
            narrow = 1'($urandom_range(1));
            send_frame(OP_SEED, seed);
            sent++;
            repeat ($urandom_range(0, 4)) begin
               send_frame(OP_CALIBRATE, calibration_frame(seed, narrow));
               sent++;
            end
            repeat ($urandom_range(1, 8)) begin
               send_frame(OP_MEASURE, measure_frame());
               sent++;
            end
         end else begin
            op = OP_BITS'($urandom_range(3));
            send_frame(op, (op == OP_MEASURE) ? measure_frame() : random_frame());
            if (op != OP_UNUSED) sent++;
         end
      end
      steady_flow = 1'b0;
   endtask

   // Receiver side: ready changes at the falling edge with random stalls.
   initial begin
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            stall_left = idle_length();
         end
      end
   end

   // Compares each accepted result with the oldest expected measure.
   always @(posedge clock) begin
      measure_type got;
      measure_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(measure_type)-1:0];
         if (pending_measures.size() == 0) begin
            $error("result item arrived with no measure outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_measures.pop_front();
            for (int i = 0; i < CHANNELS; i++) begin
               if (got.level[i] !== want.level[i]) begin
                  $error("level_%0d expected %0d got %0d", i, want.level[i], got.level[i]);
                  mismatch_count++;
               end
            end
            if (got.all_dark !== want.all_dark) begin
               $error("all_dark expected %0d got %0d", want.all_dark, got.all_dark);
               mismatch_count++;
            end
            if (got.all_light !== want.all_light) begin
               $error("all_light expected %0d got %0d", want.all_light, got.all_light);
               mismatch_count++;
            end
            if (got.any_dark !== want.any_dark) begin
               $error("any_dark expected %0d got %0d", want.any_dark, got.any_dark);
               mismatch_count++;
            end
            if (got.half_dark !== want.half_dark) begin
               $error("half_dark expected %0d got %0d", want.half_dark, got.half_dark);
               mismatch_count++;
            end
         end
      end
   end

   // Main sequence of tests.
   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_SEED;
      mismatch_count = 0;
      steady_flow = 1'b0;
      dark_level = LEVEL_BITS'(128);
      for (int i = 0; i < CHANNELS; i++) begin
         chan_lo[i] = SAMPLE_TOP[SAMPLE_BITS-1:0];
         chan_hi[i] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_seed_and_unused_op();
      test_full_range();
      test_clamping();
      test_dark_flags();
      test_threshold_extremes();
      test_random_traffic(300, LEVEL_BITS'(128), 1'b0);
      test_random_traffic(300, '0, 1'b1);
      test_random_traffic(300, LEVEL_BITS'(LEVEL_ONE), 1'b0);
      test_random_traffic(300, LEVEL_BITS'($urandom_range(1, LEVEL_ONE - 1)), 1'b0);
      test_random_traffic(300, LEVEL_BITS'($urandom_range(60, 200)), 1'b0);
      test_random_traffic(300, LEVEL_BITS'(192), 1'b0);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("sensor_array_minmax_normalizer_test passed");
      end else begin
         $display("sensor_array_minmax_normalizer_test failed");
      end
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin
      #50000000;
      $display("sensor_array_minmax_normalizer_test failed");
      $finish;
   end

endmodule
